// ===== sv/wsfd_pkg.sv =====
// wsfd_pkg: shared types, constants and codes of the websocket frame decoder
// no dependencies; used by every other file of the block except wsfd_if
package wsfd_pkg;

	// width of the payload down-counter; longer declared lengths are too large
	localparam int COUNT_WIDTH = 32;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

	// opcode of a text frame
	localparam logic [3:0] OP_TEXT = 4'h1;

	// 7-bit length codes that select an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// report status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE = 3'd3;
	localparam logic [2:0] ST_BAD_UTF8  = 3'd4;

	// parse phase
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASKKEY,
		PH_PAYLOAD,
		PH_DONE,
		PH_FAILED
	} phase_t;

	// one result item
	typedef struct packed {
		logic        data_valid;
		logic [7:0]  payload_byte;
		logic        done_res;
		logic [2:0]  status;
		logic [3:0]  frame_opcode;
		logic        masked_flag;
		logic [63:0] payload_length;
	} res_t;

	// control into the utf-8 checker
	typedef struct packed {
		logic       feed;
		logic       clr;
		logic [7:0] data;
	} utf8_ctl_t;

	// checker state after the current byte, before any clear
	typedef struct packed {
		logic bad;
		logic pending;
	} utf8_stat_t;

endpackage

// ===== sv/wsfd_if.sv =====
// wsfd_if: valid/ready channel interfaces of the websocket frame decoder
// depends on nothing; the top level uses all three
interface wsfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface wsfd_out_if;
	logic        valid;
	logic        ready;
	logic        data_valid;
	logic [7:0]  payload_byte;
	logic        done_res;
	logic [2:0]  status;
	logic [3:0]  frame_opcode;
	logic        masked_flag;
	logic [63:0] payload_length;

	modport source (output valid, data_valid, payload_byte, done_res, status, frame_opcode,
		masked_flag, payload_length, input ready);
	modport sink (input valid, data_valid, payload_byte, done_res, status, frame_opcode,
		masked_flag, payload_length, output ready);
endinterface

interface wsfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== sv/websocket_frame_decoder.sv =====
// websocket_frame_decoder: top level, header parse, unmasking and status report
// depends on wsfd_pkg, wsfd_if, wsfd_utf8 and wsfd_out_fifo
//
// Parses one received buffer as a single WebSocket frame, one byte per
// transfer on rx. Each byte is handled combinationally by the parser and its
// result (an unmasked payload byte, the end-of-buffer report, or both) enters
// a two-entry result queue that drives res. A new byte is taken every cycle;
// rx.ready drops only while both queue entries wait for res.ready. max_payload
// is written through cfg at any time the block is idle; cfg.ready is always high.
// A non-zero status on the done_res result means the payload bytes already
// delivered for that buffer are to be discarded.
module websocket_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	wsfd_cfg_if.sink    cfg,
	wsfd_in_if.sink     rx,
	wsfd_out_if.source  res
);

	wsfd_pkg::phase_t   ph_q, ph_n;
	logic [3:0]         cnt_q, cnt_n;
	logic [63:0]        len_q, len_n;
	logic [31:0]        key_q, key_n;
	wsfd_pkg::count_t   rem_q, rem_n;
	logic [1:0]         mp_q, mp_n;
	logic [2:0]         st_q, st_n;
	logic [3:0]         op_q, op_n;
	logic               mf_q, mf_n;
	logic [31:0]        max_q;

	logic               acc, emit, fifo_full, fifo_ne;
	logic [7:0]         ob, key_byte;
	logic [63:0]        len_v;
	logic               too_big;
	wsfd_pkg::res_t     res_d, res_head;
	wsfd_pkg::utf8_ctl_t  utf_ctl;
	wsfd_pkg::utf8_stat_t utf_stat;

	assign acc       = rx.valid && rx.ready;
	assign rx.ready  = !fifo_full;
	assign cfg.ready = 1'b1;

	// max_payload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= wsfd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg.valid) begin
			max_q <= cfg.data;
		end
	end

	// current mask key byte
	always_comb begin
		unique case (mp_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// parse step for the accepted byte
	always_comb begin
		ph_n    = ph_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		key_n   = key_q;
		rem_n   = rem_q;
		mp_n    = mp_q;
		st_n    = st_q;
		op_n    = op_q;
		mf_n    = mf_q;
		emit    = 1'b0;
		ob      = 8'd0;
		len_v   = 64'd0;
		too_big = 1'b0;
		utf_ctl.feed = 1'b0;
		utf_ctl.clr  = 1'b0;
		utf_ctl.data = 8'd0;
		if (acc) begin
			unique case (ph_q)
				wsfd_pkg::PH_HDR0: begin
					if (!rx.data_byte[7] || rx.data_byte[6:4] != 3'd0) begin
						st_n = wsfd_pkg::ST_BAD_HDR;
						ph_n = wsfd_pkg::PH_FAILED;
					end else begin
						op_n = rx.data_byte[3:0];
						ph_n = wsfd_pkg::PH_HDR1;
					end
				end
				wsfd_pkg::PH_HDR1, wsfd_pkg::PH_EXTLEN: begin
					// length bytes; a complete length is checked against the limits
					if (ph_q == wsfd_pkg::PH_HDR1) begin
						mf_n  = rx.data_byte[7];
						len_v = {57'd0, rx.data_byte[6:0]};
						if (rx.data_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
							cnt_n = 4'd2;
							len_v = 64'd0;
							ph_n  = wsfd_pkg::PH_EXTLEN;
						end else if (rx.data_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
							cnt_n = 4'd8;
							len_v = 64'd0;
							ph_n  = wsfd_pkg::PH_EXTLEN;
						end
					end else begin
						len_v = {len_q[55:0], rx.data_byte};
						cnt_n = cnt_q - 4'd1;
					end
					len_n = len_v;
					if (ph_n != wsfd_pkg::PH_EXTLEN || cnt_n == 4'd0) begin
						too_big = (len_v > {32'd0, max_q}) ||
							((len_v >> wsfd_pkg::COUNT_WIDTH) != 64'd0);
						if (too_big) begin
							st_n = wsfd_pkg::ST_TOO_LARGE;
							ph_n = wsfd_pkg::PH_FAILED;
						end else begin
							rem_n = len_v[wsfd_pkg::COUNT_WIDTH-1:0];
							if (mf_n) begin
								cnt_n = 4'd4;
								ph_n  = wsfd_pkg::PH_MASKKEY;
							end else begin
								mp_n = 2'd0;
								ph_n = (len_v == 64'd0) ? wsfd_pkg::PH_DONE :
									wsfd_pkg::PH_PAYLOAD;
							end
						end
					end
				end
				wsfd_pkg::PH_MASKKEY: begin
					key_n = {key_q[23:0], rx.data_byte};
					cnt_n = cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						mp_n = 2'd0;
						ph_n = (rem_q == '0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAYLOAD;
					end
				end
				wsfd_pkg::PH_PAYLOAD: begin
					ob   = mf_q ? (rx.data_byte ^ key_byte) : rx.data_byte;
					mp_n = mp_q + 2'd1;
					emit = 1'b1;
					utf_ctl.feed = op_q == wsfd_pkg::OP_TEXT;
					utf_ctl.data = ob;
					rem_n = rem_q - wsfd_pkg::count_t'(1);
					if (rem_q == wsfd_pkg::count_t'(1)) begin
						ph_n = wsfd_pkg::PH_DONE;
					end
				end
				default: begin
				end
			endcase
			utf_ctl.clr = rx.last_byte;
		end
	end

	// result item, with the end-of-buffer report
	always_comb begin
		res_d = '0;
		res_d.data_valid   = emit;
		res_d.payload_byte = ob;
		if (rx.last_byte) begin
			res_d.done_res       = 1'b1;
			res_d.frame_opcode   = op_n;
			res_d.masked_flag    = mf_n;
			res_d.payload_length = len_n;
			priority if (ph_q == wsfd_pkg::PH_HDR0) begin
				res_d.status         = wsfd_pkg::ST_TRUNCATED;
				res_d.frame_opcode   = 4'd0;
				res_d.masked_flag    = 1'b0;
				res_d.payload_length = 64'd0;
			end else if (ph_n == wsfd_pkg::PH_FAILED) begin
				res_d.status = st_n;
				if (st_n == wsfd_pkg::ST_BAD_HDR) begin
					res_d.frame_opcode   = 4'd0;
					res_d.masked_flag    = 1'b0;
					res_d.payload_length = 64'd0;
				end
			end else if (ph_n == wsfd_pkg::PH_EXTLEN) begin
				res_d.status         = wsfd_pkg::ST_TRUNCATED;
				res_d.payload_length = 64'd0;
			end else if (ph_n == wsfd_pkg::PH_MASKKEY || ph_n == wsfd_pkg::PH_PAYLOAD) begin
				res_d.status = wsfd_pkg::ST_TRUNCATED;
			end else if (op_n == wsfd_pkg::OP_TEXT && (utf_stat.bad || utf_stat.pending)) begin
				res_d.status = wsfd_pkg::ST_BAD_UTF8;
			end else begin
				res_d.status = wsfd_pkg::ST_OK;
			end
		end
	end

	// parse state; the last byte of a buffer starts the next one fresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= wsfd_pkg::PH_HDR0;
			cnt_q <= 4'd0;
			len_q <= 64'd0;
			key_q <= 32'd0;
			rem_q <= '0;
			mp_q  <= 2'd0;
			st_q  <= wsfd_pkg::ST_OK;
			op_q  <= 4'd0;
			mf_q  <= 1'b0;
		end else if (acc && rx.last_byte) begin
			ph_q  <= wsfd_pkg::PH_HDR0;
			cnt_q <= 4'd0;
			len_q <= 64'd0;
			key_q <= 32'd0;
			rem_q <= '0;
			mp_q  <= 2'd0;
			st_q  <= wsfd_pkg::ST_OK;
			op_q  <= 4'd0;
			mf_q  <= 1'b0;
		end else begin
			ph_q  <= ph_n;
			cnt_q <= cnt_n;
			len_q <= len_n;
			key_q <= key_n;
			rem_q <= rem_n;
			mp_q  <= mp_n;
			st_q  <= st_n;
			op_q  <= op_n;
			mf_q  <= mf_n;
		end
	end

	wsfd_utf8 u_utf8 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (utf_ctl),
		.stat   (utf_stat)
	);

	wsfd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && (emit || rx.last_byte)),
		.push_data (res_d),
		.pop       (res.valid && res.ready),
		.full      (fifo_full),
		.not_empty (fifo_ne),
		.head      (res_head)
	);

	// output channel
	assign res.valid          = fifo_ne;
	assign res.data_valid     = res_head.data_valid;
	assign res.payload_byte   = res_head.payload_byte;
	assign res.done_res       = res_head.done_res;
	assign res.status         = res_head.status;
	assign res.frame_opcode   = res_head.frame_opcode;
	assign res.masked_flag    = res_head.masked_flag;
	assign res.payload_length = res_head.payload_length;

	// payload phase always has bytes left to take
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero bytes remaining");

	// the last byte of a buffer returns the parser to the first header byte
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && rx.last_byte |=> ph_q == wsfd_pkg::PH_HDR0 && st_q == wsfd_pkg::ST_OK)
		else $error("parser not cleared after last byte");

	// a failed header always latches a failure status
	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_FAILED |->
			st_q == wsfd_pkg::ST_BAD_HDR || st_q == wsfd_pkg::ST_TOO_LARGE)
		else $error("failed phase without header status");

	// the mask key is only collected for masked frames
	a_key_masked: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == wsfd_pkg::PH_MASKKEY |-> mf_q && cnt_q != 4'd0)
		else $error("mask key phase on unmasked frame");

	// a result is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !fifo_full)
		else $error("result queue overflow");

endmodule

// ===== sv/wsfd_utf8.sv =====
// wsfd_utf8: incremental utf-8 validator for text payload bytes
// depends on wsfd_pkg
module wsfd_utf8 (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wsfd_pkg::utf8_ctl_t   ctl,
	output wsfd_pkg::utf8_stat_t  stat
);

	logic [1:0]  pend_q, slen_q;
	logic [20:0] cp_q;
	logic        bad_q;
	logic [1:0]  pend_n, slen_n;
	logic [20:0] cp_n;
	logic        bad_n;

	// next checker state for one byte
	always_comb begin
		pend_n = pend_q;
		slen_n = slen_q;
		cp_n   = cp_q;
		bad_n  = bad_q;
		if (ctl.feed && !bad_q) begin
			if (pend_q == 2'd0) begin
				// lead byte
				priority casez (ctl.data)
					8'b0???????: begin
					end
					8'b110?????: begin
						slen_n = 2'd1;
						pend_n = 2'd1;
						cp_n   = {16'd0, ctl.data[4:0]};
					end
					8'b1110????: begin
						slen_n = 2'd2;
						pend_n = 2'd2;
						cp_n   = {17'd0, ctl.data[3:0]};
					end
					8'b11110???: begin
						slen_n = 2'd3;
						pend_n = 2'd3;
						cp_n   = {18'd0, ctl.data[2:0]};
					end
					default: bad_n = 1'b1;
				endcase
			end else if (ctl.data[7:6] != 2'b10) begin
				bad_n = 1'b1;
			end else begin
				// continuation byte, range check at the end of the sequence
				cp_n   = {cp_q[14:0], ctl.data[5:0]};
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					unique case (slen_q)
						2'd1: bad_n = cp_n < 21'h80;
						2'd2: bad_n = (cp_n < 21'h800) || (cp_n >= 21'hD800 && cp_n <= 21'hDFFF);
						default: bad_n = (cp_n < 21'h10000) || (cp_n > 21'h10FFFF);
					endcase
				end
			end
		end
	end

	assign stat.bad     = bad_n;
	assign stat.pending = pend_n != 2'd0;

	// checker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			slen_q <= 2'd0;
			cp_q   <= 21'd0;
			bad_q  <= 1'b0;
		end else if (ctl.clr) begin
			pend_q <= 2'd0;
			slen_q <= 2'd0;
			cp_q   <= 21'd0;
			bad_q  <= 1'b0;
		end else begin
			pend_q <= pend_n;
			slen_q <= slen_n;
			cp_q   <= cp_n;
			bad_q  <= bad_n;
		end
	end

endmodule

// ===== sv/wsfd_out_fifo.sv =====
// wsfd_out_fifo: two-entry result queue between the parser and the output channel
// depends on wsfd_pkg
module wsfd_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfd_pkg::res_t  push_data,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output wsfd_pkg::res_t  head
);

	wsfd_pkg::res_t mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sim/websocket_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// websocket_frame_decoder_test: self-checking testbench of the websocket frame decoder
// depends on wsfd_pkg, the channel interfaces of wsfd_if and websocket_frame_decoder
module websocket_frame_decoder_test;

	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES = 640;
	localparam int CALM_BYTES = 150;

	typedef enum logic [1:0] {ENT_BYTE, ENT_CFG, ENT_DRAIN} entry_kind_t;

	// one pending step for the driver: a byte, a register write or a drain
	typedef struct packed {
		entry_kind_t kind;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] cfg_word;
		logic        calm;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	wsfd_cfg_if cfg_ch ();
	wsfd_in_if  rx_ch ();
	wsfd_out_if res_ch ();

	websocket_frame_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	entry_t          pending[$];
	wsfd_pkg::res_t  frame_results[$];
	logic [7:0]      body[$];
	int              errors = 0;
	int              queued_bytes = 0;
	int              tx_gap;
	int              rx_stall;
	int              settle;
	logic            calm;
	logic            quiet_mode = 1'b0;

	// clock and reset
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// frame parser state of the predictor
	wsfd_pkg::phase_t ps_phase;
	logic [3:0]  ps_hdr_left;
	logic [63:0] ps_len;
	logic [31:0] ps_key;
	logic [63:0] ps_left;
	logic [1:0]  ps_key_pos;
	logic [2:0]  ps_fail_status;
	logic [3:0]  ps_opcode;
	logic        ps_masked;
	logic [1:0]  ps_utf_left;
	logic [1:0]  ps_utf_len;
	logic [20:0] ps_cp;
	logic        ps_utf_bad;
	logic [31:0] ps_max_len;

	function automatic void clear_frame();
		ps_phase = wsfd_pkg::PH_HDR0;
		ps_hdr_left = '0;
		ps_len = '0;
		ps_key = '0;
		ps_left = '0;
		ps_key_pos = '0;
		ps_fail_status = wsfd_pkg::ST_OK;
		ps_opcode = '0;
		ps_masked = 1'b0;
		ps_utf_left = '0;
		ps_utf_len = '0;
		ps_cp = '0;
		ps_utf_bad = 1'b0;
	endfunction

	function automatic void start_payload();
		ps_key_pos = '0;
		ps_utf_left = '0;
		ps_utf_len = '0;
		ps_cp = '0;
		ps_utf_bad = 1'b0;
		ps_phase = (ps_left == 64'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAYLOAD;
	endfunction

	// length known: limit check, then mask key or payload
	function automatic void length_complete();
		if (ps_len > {32'd0, ps_max_len} || (ps_len >> wsfd_pkg::COUNT_WIDTH) != 64'd0) begin
			ps_fail_status = wsfd_pkg::ST_TOO_LARGE;
			ps_phase = wsfd_pkg::PH_FAILED;
			return;
		end
		ps_left = ps_len;
		if (ps_masked) begin
			ps_hdr_left = 4'd4;
			ps_phase = wsfd_pkg::PH_MASKKEY;
		end else begin
			start_payload();
		end
	endfunction

	// incremental utf-8 check of one unmasked text byte
	function automatic void utf8_step(input logic [7:0] b);
		if (ps_utf_bad)
			return;
		if (ps_utf_left == 2'd0) begin
			if (!b[7])
				return;
			if (b[7:5] == 3'b110) begin
				ps_utf_len = 2'd1;
				ps_cp = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				ps_utf_len = 2'd2;
				ps_cp = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				ps_utf_len = 2'd3;
				ps_cp = {18'd0, b[2:0]};
			end else begin
				ps_utf_bad = 1'b1;
				return;
			end
			ps_utf_left = ps_utf_len;
			return;
		end
		if (b[7:6] != 2'b10) begin
			ps_utf_bad = 1'b1;
			return;
		end
		ps_cp = {ps_cp[14:0], b[5:0]};
		ps_utf_left = ps_utf_left - 2'd1;
		if (ps_utf_left != 2'd0)
			return;
		// overlong forms, surrogates and code points past the unicode range
		case (ps_utf_len)
			2'd1: if (ps_cp < 21'h80) ps_utf_bad = 1'b1;
			2'd2: if (ps_cp < 21'h800 || (ps_cp >= 21'hD800 && ps_cp <= 21'hDFFF))
				ps_utf_bad = 1'b1;
			default: if (ps_cp < 21'h10000 || ps_cp > 21'h10FFFF) ps_utf_bad = 1'b1;
		endcase
	endfunction

	// one received byte; returns 1 when it yields a result
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
		output wsfd_pkg::res_t r);
		wsfd_pkg::phase_t at_entry;
		bit         emit;
		logic [7:0] ob;
		logic [2:0] st;
		bit         show_hdr;
		bit         show_len;
		at_entry = ps_phase;
		emit = 1'b0;
		ob = 8'h00;
		r = '0;
		case (ps_phase)
			wsfd_pkg::PH_HDR0: begin
				if (!b[7] || b[6:4] != 3'b000) begin
					ps_fail_status = wsfd_pkg::ST_BAD_HDR;
					ps_phase = wsfd_pkg::PH_FAILED;
				end else begin
					ps_opcode = b[3:0];
					ps_phase = wsfd_pkg::PH_HDR1;
				end
			end
			wsfd_pkg::PH_HDR1: begin
				ps_masked = b[7];
				ps_len = '0;
				if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
					ps_hdr_left = 4'd2;
					ps_phase = wsfd_pkg::PH_EXTLEN;
				end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
					ps_hdr_left = 4'd8;
					ps_phase = wsfd_pkg::PH_EXTLEN;
				end else begin
					ps_len = {57'd0, b[6:0]};
					length_complete();
				end
			end
			wsfd_pkg::PH_EXTLEN: begin
				ps_len = {ps_len[55:0], b};
				ps_hdr_left = ps_hdr_left - 4'd1;
				if (ps_hdr_left == 4'd0)
					length_complete();
			end
			wsfd_pkg::PH_MASKKEY: begin
				ps_key = {ps_key[23:0], b};
				ps_hdr_left = ps_hdr_left - 4'd1;
				if (ps_hdr_left == 4'd0)
					start_payload();
			end
			wsfd_pkg::PH_PAYLOAD: begin
				ob = b;
				if (ps_masked)
					ob = ob ^ ps_key[24 - 8 * int'(ps_key_pos) +: 8];
				ps_key_pos = ps_key_pos + 2'd1;
				emit = 1'b1;
				if (ps_opcode == wsfd_pkg::OP_TEXT)
					utf8_step(ob);
				ps_left = ps_left - 64'd1;
				if (ps_left == 64'd0)
					ps_phase = wsfd_pkg::PH_DONE;
			end
			default: ;
		endcase
		if (!emit && !last)
			return 1'b0;
		r.data_valid = emit;
		r.payload_byte = ob;
		// end-of-buffer report
		if (last) begin
			show_hdr = 1'b1;
			show_len = 1'b1;
			if (at_entry == wsfd_pkg::PH_HDR0) begin
				st = wsfd_pkg::ST_TRUNCATED;
				show_hdr = 1'b0;
				show_len = 1'b0;
			end else if (ps_phase == wsfd_pkg::PH_FAILED) begin
				st = ps_fail_status;
				if (st == wsfd_pkg::ST_BAD_HDR) begin
					show_hdr = 1'b0;
					show_len = 1'b0;
				end
			end else if (ps_phase == wsfd_pkg::PH_EXTLEN) begin
				st = wsfd_pkg::ST_TRUNCATED;
				show_len = 1'b0;
			end else if (ps_phase == wsfd_pkg::PH_MASKKEY ||
				ps_phase == wsfd_pkg::PH_PAYLOAD) begin
				st = wsfd_pkg::ST_TRUNCATED;
			end else begin
				st = wsfd_pkg::ST_OK;
				if (ps_opcode == wsfd_pkg::OP_TEXT && (ps_utf_bad || ps_utf_left != 2'd0))
					st = wsfd_pkg::ST_BAD_UTF8;
			end
			r.done_res = 1'b1;
			r.status = st;
			r.frame_opcode = show_hdr ? ps_opcode : 4'h0;
			r.masked_flag = show_hdr ? ps_masked : 1'b0;
			r.payload_length = show_len ? ps_len : 64'd0;
			clear_frame();
		end
		return 1'b1;
	endfunction

	// driver: byte and register write transfers, sender gaps
	always @(posedge clk or negedge arst_n) begin
		wsfd_pkg::res_t r;
		entry_t head;
		logic   hold_rx;
		logic   hold_cfg;
		logic   nxt_rx;
		logic   nxt_cfg;
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.data_byte <= 8'h00;
			rx_ch.last_byte <= 1'b0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.data <= 32'd0;
			tx_gap = 0;
			settle = 0;
			calm = 1'b0;
			ps_max_len = wsfd_pkg::MAX_PAYLOAD_RESET;
			clear_frame();
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				if (decode_byte(rx_ch.data_byte, rx_ch.last_byte, r))
					frame_results.push_back(r);
			end
			if (cfg_ch.valid && cfg_ch.ready)
				ps_max_len = cfg_ch.data;
			hold_rx = rx_ch.valid && !rx_ch.ready;
			hold_cfg = cfg_ch.valid && !cfg_ch.ready;
			nxt_rx = hold_rx;
			nxt_cfg = hold_cfg;
			// idle cycles with nothing in flight, before a register write or a drain ends
			if (frame_results.size() == 0 && !rx_ch.valid && !cfg_ch.valid)
				settle++;
			else
				settle = 0;
			if (!hold_rx && !hold_cfg) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending.size() > 0) begin
					head = pending[0];
					calm = head.calm;
					if (head.kind == ENT_BYTE) begin
						if (!head.calm && $urandom_range(0, 15) == 0) begin
							tx_gap = $urandom_range(0, 13);
						end else begin
							head = pending.pop_front();
							nxt_rx = 1'b1;
							rx_ch.data_byte <= head.data_byte;
							rx_ch.last_byte <= head.last_byte;
						end
					end else if (settle >= SETTLE_CYCLES) begin
						head = pending.pop_front();
						if (head.kind == ENT_CFG) begin
							nxt_cfg = 1'b1;
							cfg_ch.data <= head.cfg_word;
						end
					end
				end
			end
			rx_ch.valid <= nxt_rx;
			cfg_ch.valid <= nxt_cfg;
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// monitor: result transfers against the oldest expectation, receiver stalls
	always @(posedge clk or negedge arst_n) begin
		wsfd_pkg::res_t got;
		wsfd_pkg::res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.data_valid, res_ch.payload_byte, res_ch.done_res, res_ch.status,
					res_ch.frame_opcode, res_ch.masked_flag, res_ch.payload_length};
				if (frame_results.size() == 0) begin
					errors++;
					$error("result with nothing expected: %0h", got);
				end else begin
					want = frame_results.pop_front();
					check_field("data_valid", 64'(want.data_valid), 64'(got.data_valid));
					check_field("payload_byte", 64'(want.payload_byte),
						64'(got.payload_byte));
					check_field("done_res", 64'(want.done_res), 64'(got.done_res));
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("frame_opcode", 64'(want.frame_opcode),
						64'(got.frame_opcode));
					check_field("masked_flag", 64'(want.masked_flag), 64'(got.masked_flag));
					check_field("payload_length", want.payload_length, got.payload_length);
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				rx_stall = $urandom_range(0, 13);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus building
	task automatic add_byte(input logic [7:0] b, input logic last);
		entry_t e;
		e = '0;
		e.kind = ENT_BYTE;
		e.data_byte = b;
		e.last_byte = last;
		e.calm = quiet_mode;
		pending.push_back(e);
		queued_bytes++;
	endtask

	task automatic add_cfg(input logic [31:0] v);
		entry_t e;
		e = '0;
		e.kind = ENT_CFG;
		e.cfg_word = v;
		e.calm = quiet_mode;
		pending.push_back(e);
	endtask

	task automatic add_drain();
		entry_t e;
		e = '0;
		e.kind = ENT_DRAIN;
		e.calm = quiet_mode;
		pending.push_back(e);
	endtask

	// body from the low n bytes of w, first byte most significant
	task automatic fill(input logic [63:0] w, input int n);
		body.delete();
		for (int i = n - 1; i >= 0; i--)
			body.push_back(w[8 * i +: 8]);
	endtask

	// one buffer: header, length encoding, key, masked body, trailing bytes, optional cut
	task automatic add_frame(input logic [7:0] b0, input logic mask, input int enc,
		input logic [63:0] declared, input logic [31:0] key, input int trail, input int cut);
		logic [7:0] octets[$];
		int         n;
		octets.push_back(b0);
		case (enc)
			0: octets.push_back({mask, declared[6:0]});
			1: begin
				octets.push_back({mask, wsfd_pkg::LEN_EXT16});
				octets.push_back(declared[15:8]);
				octets.push_back(declared[7:0]);
			end
			default: begin
				octets.push_back({mask, wsfd_pkg::LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					octets.push_back(declared[8 * i +: 8]);
			end
		endcase
		if (mask)
			for (int i = 3; i >= 0; i--)
				octets.push_back(key[8 * i +: 8]);
		for (int i = 0; i < body.size(); i++)
			octets.push_back(body[i] ^ (mask ? key[8 * (3 - i % 4) +: 8] : 8'h00));
		repeat (trail)
			octets.push_back(8'($urandom_range(0, 255)));
		n = (cut > 0 && cut < octets.size()) ? cut : octets.size();
		for (int i = 0; i < n; i++)
			add_byte(octets[i], i == n - 1);
	endtask

	// one random character, mostly well-formed utf-8
	task automatic add_char();
		int unsigned pick;
		logic [20:0] cp;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			body.push_back(8'($urandom_range(0, 127)));
		end else if (pick < 70) begin
			cp = 21'($urandom_range(21'h80, 21'h7FF));
			body.push_back({3'b110, cp[10:6]});
			body.push_back({2'b10, cp[5:0]});
		end else if (pick < 83) begin
			cp = 21'($urandom_range(21'h800, 21'hFFFF));
			body.push_back({4'b1110, cp[15:12]});
			body.push_back({2'b10, cp[11:6]});
			body.push_back({2'b10, cp[5:0]});
		end else if (pick < 96) begin
			cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
			body.push_back({5'b11110, cp[20:18]});
			body.push_back({2'b10, cp[17:12]});
			body.push_back({2'b10, cp[11:6]});
			body.push_back({2'b10, cp[5:0]});
		end else begin
			body.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_random_frame();
		logic [7:0]  b0;
		logic [3:0]  op;
		logic        mask;
		logic [63:0] declared;
		int          enc;
		int          sel;
		int          k;
		int          trail;
		int          cut;
		sel = $urandom_range(0, 99);
		op = (sel < 50) ? wsfd_pkg::OP_TEXT : (sel < 75) ? 4'h2 : 4'($urandom_range(0, 15));
		b0 = {4'b1000, op};
		if ($urandom_range(0, 9) == 0)
			b0 = 8'($urandom_range(0, 255));
		mask = 1'($urandom_range(0, 1));
		body.delete();
		if (op == wsfd_pkg::OP_TEXT) begin
			k = $urandom_range(0, 8);
			repeat (k) add_char();
			// sometimes end inside a sequence
			if ($urandom_range(0, 9) == 0 && body.size() > 0)
				void'(body.pop_back());
		end else begin
			k = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
			repeat (k) body.push_back(8'($urandom_range(0, 255)));
		end
		declared = 64'(body.size());
		sel = $urandom_range(0, 99);
		enc = (sel < 75) ? 0 : (sel < 90) ? 1 : 2;
		// occasional huge declared length
		if ($urandom_range(0, 19) == 0) begin
			declared = {$urandom, $urandom};
			enc = 2;
		end
		trail = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6 + body.size()) : 0;
		add_frame(b0, mask, enc, declared, $urandom, trail, cut);
	endtask

	initial begin
		int          frames;
		int          random_end;
		logic [31:0] limit_word;
		// one-byte buffers, good and malformed first byte
		add_byte(8'h81, 1'b1);
		add_byte(8'h01, 1'b1);
		// fin clear and rsv set: rest of buffer ignored
		fill(64'h6869, 2);
		add_frame(8'h01, 1'b0, 0, 64'd2, 32'h0, 2, 0);
		add_frame(8'hF1, 1'b1, 0, 64'd2, 32'h12345678, 0, 0);
		// empty text, masked binary with extreme bytes
		body.delete();
		add_frame(8'h81, 1'b0, 0, 64'd0, 32'h0, 0, 0);
		fill(64'h00FF55AA80017F, 7);
		add_frame(8'h82, 1'b1, 0, 64'd7, 32'hFFFFFFFF, 0, 0);
		add_frame(8'h8F, 1'b0, 1, 64'd7, 32'h0, 0, 0);
		// buffer ends inside the extended length and inside the mask key
		add_frame(8'h82, 1'b0, 1, 64'd7, 32'h0, 0, 2);
		add_frame(8'h82, 1'b1, 2, 64'd7, 32'hA5A5A5A5, 0, 12);
		// huge length, and a long length cut short
		add_frame(8'h82, 1'b0, 2, 64'hFFFFFFFFFFFFFFFF, 32'h0, 3, 0);
		add_frame(8'h82, 1'b1, 1, 64'h0000_0000_0000_FFFF, 32'h0102_0304, 0, 14);
		// utf-8: valid mix, overlong, surrogate, beyond range, bad continuation, bad lead
		fill(64'hC3A9E282ACF09F98, 8);
		body.push_back(8'h80);
		add_frame(8'h81, 1'b1, 0, 64'd9, 32'hDEADBEEF, 0, 0);
		fill(64'hC080, 2);
		add_frame(8'h81, 1'b0, 0, 64'd2, 32'h0, 0, 0);
		fill(64'hE08080, 3);
		add_frame(8'h81, 1'b0, 0, 64'd3, 32'h0, 0, 0);
		fill(64'hEDA080, 3);
		add_frame(8'h81, 1'b1, 0, 64'd3, 32'h0F0F0F0F, 0, 0);
		fill(64'hF4908080, 4);
		add_frame(8'h81, 1'b0, 0, 64'd4, 32'h0, 0, 0);
		fill(64'hC341, 2);
		add_frame(8'h81, 1'b0, 0, 64'd2, 32'h0, 0, 0);
		fill(64'h41FF80, 3);
		add_frame(8'h81, 1'b0, 0, 64'd3, 32'h0, 0, 0);
		// text ends inside a sequence, and truncation wins over bad utf-8
		fill(64'h41E282, 3);
		add_frame(8'h81, 1'b0, 0, 64'd3, 32'h0, 0, 0);
		fill(64'hC08078, 3);
		add_frame(8'h81, 1'b0, 0, 64'd3, 32'h0, 0, 4);
		// trailing bytes after a complete payload
		fill(64'h616263, 3);
		add_frame(8'h81, 1'b1, 0, 64'd3, 32'h00000000, 3, 0);
		// smallest limit
		add_cfg(32'd0);
		body.delete();
		add_frame(8'h82, 1'b0, 0, 64'd0, 32'h0, 0, 0);
		fill(64'h55, 1);
		add_frame(8'h82, 1'b1, 0, 64'd1, 32'h11223344, 2, 0);
		// largest limit: lengths past the counter width are too large
		add_cfg(32'hFFFFFFFF);
		fill(64'h0102030405, 5);
		add_frame(8'h82, 1'b0, 2, 64'h0000_0001_0000_0000, 32'h0, 0, 0);
		add_frame(8'h82, 1'b0, 2, 64'h0000_0000_FFFF_FFFF, 32'h0, 0, 0);
		add_frame(8'h82, 1'b0, 2, 64'h0000_0000_FFFF_FFFF, 32'h0, 0, 13);

		// random frames, limit changes between phases, a calm tail
		random_end = queued_bytes + RANDOM_BYTES;
		frames = 0;
		while (queued_bytes < random_end) begin
			if (queued_bytes > random_end - CALM_BYTES)
				quiet_mode = 1'b1;
			if (frames == 20)
				add_drain();
			if (frames % 12 == 11 && !quiet_mode) begin
				case ($urandom_range(0, 5))
					0: limit_word = 32'd0;
					1: limit_word = 32'hFFFFFFFF;
					2: limit_word = $urandom_range(0, 40);
					3: limit_word = wsfd_pkg::MAX_PAYLOAD_RESET;
					4: limit_word = $urandom;
					default: limit_word = $urandom_range(0, 300);
				endcase
				add_cfg(limit_word);
			end
			add_random_frame();
			frames++;
		end

		// wait for all transfers and results, then a short settle
		do @(negedge clk);
		while (pending.size() != 0 || rx_ch.valid || cfg_ch.valid || frame_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#10ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
